/* design/smts_pkg.sv */
// ----------------------------------------------------------------------------
// smts_pkg
// Shared widths, codes and control structs of the seasonal Markov chain
// trainer and sampler.
// ----------------------------------------------------------------------------
package smts_pkg;

	// sizing
	localparam int STATES      = 8;
	localparam int PERIOD_MAX  = 32;
	localparam int COUNT_BITS  = 24;
	localparam int RAND_BITS   = 16;

	localparam int STATE_BITS  = $clog2(STATES);
	localparam int PHASE_BITS  = $clog2(PERIOD_MAX);
	localparam int PERIOD_BITS = $clog2(PERIOD_MAX + 1);

	// pair table: {phase, src, psrc}; transition table: {pair index, dest}
	localparam int PT_AW       = PHASE_BITS + 2 * STATE_BITS;
	localparam int TT_AW       = PT_AW + STATE_BITS;
	localparam int PT_DEPTH    = 2 ** PT_AW;
	localparam int TT_DEPTH    = 2 ** TT_AW;

	localparam int PROD_BITS   = RAND_BITS + COUNT_BITS;
	localparam int CUM_BITS    = COUNT_BITS + STATE_BITS;
	localparam int CMP_BITS    = CUM_BITS + RAND_BITS;

	localparam logic [COUNT_BITS-1:0] PAIR_FULL = {COUNT_BITS{1'b1}};

	// port field widths
	localparam int OPCODE_W    = 2;
	localparam int STATE_W     = 3;
	localparam int PHASE_W     = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 6;

	typedef enum logic [OPCODE_W-1:0] {
		OP_OBSERVE       = 2'd0,
		OP_GENERATE      = 2'd1,
		OP_RESTART_TRAIN = 2'd2,
		OP_RESTART_GEN   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD   = 2'd0,
		CFG_SEASONAL = 2'd1,
		CFG_ZERO     = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OBS,
		ST_GMUL,
		ST_GWALK,
		ST_GOUT
	} ctrl_state_t;

	// effective configuration
	typedef struct packed {
		logic [PERIOD_BITS-1:0] period;
		logic                   seasonal;
		logic [STATE_BITS-1:0]  zero;
	} cfg_t;

	// commands to the context registers
	typedef struct packed {
		logic                  fill;
		logic                  clr_valid;
		logic                  first;
		logic                  advance;
		logic [STATE_BITS-1:0] value;
	} ctx_cmd_t;

	// context seen by the controller
	typedef struct packed {
		logic [STATE_BITS-1:0] cur_state;
		logic [STATE_BITS-1:0] oldest;
		logic [PHASE_BITS-1:0] phase;
		logic                  cur_valid;
	} ctx_t;

	typedef struct packed {
		logic                  we;
		logic [PT_AW-1:0]      waddr;
		logic [COUNT_BITS-1:0] wdata;
		logic [PT_AW-1:0]      raddr;
	} pt_req_t;

	typedef struct packed {
		logic                  we;
		logic [TT_AW-1:0]      waddr;
		logic [COUNT_BITS-1:0] wdata;
		logic [TT_AW-1:0]      raddr;
	} tt_req_t;

endpackage

/* design/smts_item_if.sv */
// ----------------------------------------------------------------------------
// smts_item_if
// Input channel: one command beat per handshake.
// ----------------------------------------------------------------------------
interface smts_item_if;
	logic                           valid;
	logic                           ready;
	logic [smts_pkg::OPCODE_W-1:0]  opcode;
	logic [smts_pkg::STATE_W-1:0]   observed_state;
	logic [smts_pkg::RAND_BITS-1:0] random_fraction;

	modport source (output valid, output opcode, output observed_state,
		output random_fraction, input ready);
	modport sink (input valid, input opcode, input observed_state,
		input random_fraction, output ready);
endinterface

/* design/smts_result_if.sv */
// ----------------------------------------------------------------------------
// smts_result_if
// Output channel: one generated state per beat.
// ----------------------------------------------------------------------------
interface smts_result_if;
	logic                         valid;
	logic                         ready;
	logic [smts_pkg::STATE_W-1:0] next_state;
	logic                         unseen_context;
	logic [smts_pkg::PHASE_W-1:0] phase_used;

	modport source (output valid, output next_state, output unseen_context,
		output phase_used, input ready);
	modport sink (input valid, input next_state, input unseen_context,
		input phase_used, output ready);
endinterface

/* design/smts_ram.sv */
// ----------------------------------------------------------------------------
// smts_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module smts_ram #(
	parameter int DEPTH     = 16,
	parameter int WIDTH     = 8,
	parameter int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* design/smts_ctx.sv */
// ----------------------------------------------------------------------------
// smts_ctx
// Chain context: seasonal history delay line, current state, valid flag
// and season phase.
// ----------------------------------------------------------------------------
module smts_ctx (
	input  logic               clk,
	input  logic               arst_n,
	input  smts_pkg::cfg_t     cfg,
	input  smts_pkg::ctx_cmd_t cmd,
	output smts_pkg::ctx_t     ctx
);

	logic [smts_pkg::STATE_BITS-1:0]  hist_q [smts_pkg::PERIOD_MAX];
	logic [smts_pkg::STATE_BITS-1:0]  hist_d [smts_pkg::PERIOD_MAX];
	logic [smts_pkg::STATE_BITS-1:0]  cur_q;
	logic                             valid_q;
	logic [smts_pkg::PHASE_BITS-1:0]  phase_q;
	logic [smts_pkg::PHASE_BITS-1:0]  phase_d;
	logic [smts_pkg::PERIOD_BITS-1:0] phase_inc;

	// the slot at period-1 is the newest; slot 0 is one period old
	always_comb begin
		for (int i = 0; i < smts_pkg::PERIOD_MAX; i++) begin
			hist_d[i] = hist_q[i];
			if (cmd.fill) begin
				hist_d[i] = cfg.zero;
			end else if ((cmd.first || cmd.advance) &&
				smts_pkg::PERIOD_BITS'(i + 1) == cfg.period) begin
				hist_d[i] = cmd.value;
			end else if (cmd.advance && smts_pkg::PERIOD_BITS'(i + 1) < cfg.period) begin
				hist_d[i] = hist_q[(i + 1) % smts_pkg::PERIOD_MAX];
			end
		end
	end

	always_comb begin
		phase_inc = smts_pkg::PERIOD_BITS'(phase_q) + 1'b1;
		phase_d   = phase_q;
		if (cmd.fill) begin
			phase_d = '0;
		end else if (cmd.advance && cfg.seasonal) begin
			// wrap once the phase reaches the period
			phase_d = (phase_inc >= cfg.period) ? '0 :
				phase_inc[smts_pkg::PHASE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < smts_pkg::PERIOD_MAX; i++) begin
				hist_q[i] <= '0;
			end
			cur_q   <= '0;
			valid_q <= 1'b0;
			phase_q <= '0;
		end else begin
			hist_q  <= hist_d;
			phase_q <= phase_d;
			if (cmd.fill) begin
				cur_q   <= cfg.zero;
				valid_q <= !cmd.clr_valid;
			end else if (cmd.first || cmd.advance) begin
				cur_q   <= cmd.value;
				valid_q <= 1'b1;
			end
		end
	end

	assign ctx.cur_state = cur_q;
	assign ctx.oldest    = hist_q[0];
	assign ctx.phase     = phase_q;
	assign ctx.cur_valid = valid_q;

	a_fill_resets: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |=> (phase_q == '0 && cur_q == $past(cfg.zero)))
		else $error("restart did not reset phase and state");

	a_advance_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.advance && !cmd.fill) |=> (valid_q && cur_q == $past(cmd.value)))
		else $error("advance did not take the new state");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.advance && !cmd.fill && cfg.seasonal) |=>
		(smts_pkg::PERIOD_BITS'(phase_q) < $past(cfg.period)))
		else $error("phase left the period after advance");

endmodule

/* design/smts_ctrl.sv */
// ----------------------------------------------------------------------------
// smts_ctrl
// Sequencer: table clearing sweep, observe read-modify-write, generate
// walk over cumulative counts, and the result register.
// ----------------------------------------------------------------------------
module smts_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	smts_item_if.sink                       item,
	smts_result_if.source                   result,
	input  smts_pkg::cfg_t                  cfg,
	input  smts_pkg::ctx_t                  ctx,
	output smts_pkg::ctx_cmd_t              ctx_cmd,
	output smts_pkg::pt_req_t               pt_req,
	output smts_pkg::tt_req_t               tt_req,
	input  logic [smts_pkg::COUNT_BITS-1:0] pt_rd,
	input  logic [smts_pkg::COUNT_BITS-1:0] tt_rd
);

	smts_pkg::ctrl_state_t state_q, state_d;

	logic [smts_pkg::TT_AW-1:0]      clr_addr_q;
	logic [smts_pkg::PT_AW-1:0]      pidx_q;
	logic [smts_pkg::STATE_BITS-1:0] obs_q;
	logic [smts_pkg::RAND_BITS-1:0]  rand_q;
	logic [smts_pkg::PHASE_BITS-1:0] tphase_q;
	logic [smts_pkg::PROD_BITS-1:0]  prod_q;
	logic [smts_pkg::CUM_BITS-1:0]   cum_q;
	logic [smts_pkg::STATE_BITS-1:0] j_q;
	logic [smts_pkg::STATE_BITS-1:0] dest_q;
	logic                            unseen_q;

	logic                            out_valid_q;
	logic [smts_pkg::STATE_W-1:0]    out_state_q;
	logic                            out_unseen_q;
	logic [smts_pkg::PHASE_W-1:0]    out_phase_q;

	logic [smts_pkg::PHASE_BITS-1:0] tphase;
	logic [smts_pkg::PT_AW-1:0]      pidx_now;
	logic [smts_pkg::STATE_BITS-1:0] obs_now;
	logic                            obs_ok;
	logic                            accept;
	logic [smts_pkg::CUM_BITS-1:0]   cum_next;
	logic                            hit;
	logic                            out_load;

	assign tphase   = cfg.seasonal ? ctx.phase : '0;
	assign pidx_now = {tphase, ctx.cur_state, ctx.oldest};
	assign obs_now  = item.observed_state[smts_pkg::STATE_BITS-1:0];
	assign obs_ok   = 32'(item.observed_state) < smts_pkg::STATES;
	assign accept   = item.valid && item.ready;

	// walk step: first dest whose cumulative count passes r * pair_count
	assign cum_next = cum_q + smts_pkg::CUM_BITS'(tt_rd);
	assign hit      = smts_pkg::CMP_BITS'(prod_q) < {cum_next, smts_pkg::RAND_BITS'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smts_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		item.ready   = 1'b0;
		ctx_cmd      = '0;
		out_load     = 1'b0;
		pt_req.we    = 1'b0;
		pt_req.waddr = pidx_q;
		pt_req.wdata = pt_rd + 1'b1;
		pt_req.raddr = pidx_now;
		tt_req.we    = 1'b0;
		tt_req.waddr = {pidx_q, obs_q};
		tt_req.wdata = tt_rd + 1'b1;
		tt_req.raddr = {pidx_now, obs_now};
		case (state_q)
			smts_pkg::ST_CLEAR: begin
				pt_req.we    = 1'b1;
				pt_req.waddr = clr_addr_q[smts_pkg::PT_AW-1:0];
				pt_req.wdata = '0;
				tt_req.we    = 1'b1;
				tt_req.waddr = clr_addr_q;
				tt_req.wdata = '0;
				if (clr_addr_q == smts_pkg::TT_AW'(smts_pkg::TT_DEPTH - 1)) begin
					state_d = smts_pkg::ST_IDLE;
				end
			end
			smts_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					case (smts_pkg::op_t'(item.opcode))
						smts_pkg::OP_OBSERVE: begin
							if (obs_ok) begin
								if (!ctx.cur_valid) begin
									ctx_cmd.first = 1'b1;
									ctx_cmd.value = obs_now;
								end else begin
									state_d = smts_pkg::ST_OBS;
								end
							end
						end
						smts_pkg::OP_GENERATE: begin
							state_d = smts_pkg::ST_GMUL;
						end
						smts_pkg::OP_RESTART_TRAIN: begin
							ctx_cmd.fill      = 1'b1;
							ctx_cmd.clr_valid = 1'b1;
							state_d           = smts_pkg::ST_CLEAR;
						end
						smts_pkg::OP_RESTART_GEN: begin
							ctx_cmd.fill = 1'b1;
						end
						default: begin
							state_d = smts_pkg::ST_IDLE;
						end
					endcase
				end
			end
			smts_pkg::ST_OBS: begin
				// drop the observation when the pair count is saturated
				if (pt_rd != smts_pkg::PAIR_FULL) begin
					pt_req.we       = 1'b1;
					tt_req.we       = 1'b1;
					ctx_cmd.advance = 1'b1;
					ctx_cmd.value   = obs_q;
				end
				state_d = smts_pkg::ST_IDLE;
			end
			smts_pkg::ST_GMUL: begin
				tt_req.raddr = {pidx_q, smts_pkg::STATE_BITS'(0)};
				state_d = (pt_rd == '0) ? smts_pkg::ST_GOUT : smts_pkg::ST_GWALK;
			end
			smts_pkg::ST_GWALK: begin
				tt_req.raddr = {pidx_q, smts_pkg::STATE_BITS'(j_q + 1'b1)};
				if (hit || j_q == smts_pkg::STATE_BITS'(smts_pkg::STATES - 1)) begin
					state_d = smts_pkg::ST_GOUT;
				end
			end
			smts_pkg::ST_GOUT: begin
				// hold until the result register is free
				if (!out_valid_q || result.ready) begin
					out_load        = 1'b1;
					ctx_cmd.advance = 1'b1;
					ctx_cmd.value   = dest_q;
					state_d         = smts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = smts_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (state_q == smts_pkg::ST_CLEAR) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end else begin
			clr_addr_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == smts_pkg::ST_IDLE && accept) begin
			pidx_q   <= pidx_now;
			obs_q    <= obs_now;
			rand_q   <= item.random_fraction;
			tphase_q <= tphase;
		end
		case (state_q)
			smts_pkg::ST_GMUL: begin
				prod_q   <= smts_pkg::PROD_BITS'(rand_q) * smts_pkg::PROD_BITS'(pt_rd);
				cum_q    <= '0;
				j_q      <= '0;
				unseen_q <= (pt_rd == '0);
				dest_q   <= cfg.zero;
			end
			smts_pkg::ST_GWALK: begin
				cum_q <= cum_next;
				j_q   <= j_q + 1'b1;
				if (hit) begin
					dest_q <= j_q;
				end
			end
			default: begin
				cum_q <= cum_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_state_q  <= smts_pkg::STATE_W'(dest_q);
			out_unseen_q <= unseen_q;
			out_phase_q  <= smts_pkg::PHASE_W'(tphase_q);
		end
	end

	assign result.valid          = out_valid_q;
	assign result.next_state     = out_state_q;
	assign result.unseen_context = out_unseen_q;
	assign result.phase_used     = out_phase_q;

	a_result_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == smts_pkg::ST_GOUT)
		else $error("result beat raised outside the output step");

	a_no_count_past_full: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_req.we && state_q != smts_pkg::ST_CLEAR) |-> pt_rd != smts_pkg::PAIR_FULL)
		else $error("pair count incremented past saturation");

	a_gen_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smts_pkg::ST_IDLE && accept &&
		item.opcode == smts_pkg::OP_GENERATE) |=> state_q == smts_pkg::ST_GMUL)
		else $error("generate beat did not start a walk");

endmodule

/* design/seasonal_markov_train_and_sample.sv */
// ----------------------------------------------------------------------------
// seasonal_markov_train_and_sample
// Seasonal second-order Markov chain trainer and sampler with count tables
// held in block memories.
// ----------------------------------------------------------------------------
// Observe: read the counts, then write them back. The first observe after a
// restart, and restart generation, act in the idle step. Generate: read the
// pair count and form the product, walk 0..8 entries one per cycle (0 for an
// unseen context), then load the result register once it is free.
// Reset and restart training run a clearing pass over the 16384 table entries
// (one entry a cycle) with item ready low; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
module seasonal_markov_train_and_sample (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [smts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smts_pkg::CFG_DATA_W-1:0] cfg_data,
	smts_item_if.sink                       item,
	smts_result_if.source                   result
);

	logic [smts_pkg::CFG_DATA_W-1:0] period_q;
	logic                            seasonal_q;
	logic [smts_pkg::STATE_W-1:0]    zero_q;

	smts_pkg::cfg_t     cfg;
	smts_pkg::ctx_t     ctx;
	smts_pkg::ctx_cmd_t ctx_cmd;
	smts_pkg::pt_req_t  pt_req;
	smts_pkg::tt_req_t  tt_req;

	logic [smts_pkg::COUNT_BITS-1:0] pt_rd;
	logic [smts_pkg::COUNT_BITS-1:0] tt_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= smts_pkg::CFG_DATA_W'(1);
			seasonal_q <= 1'b0;
			zero_q     <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				smts_pkg::CFG_PERIOD:   period_q   <= cfg_data;
				smts_pkg::CFG_SEASONAL: seasonal_q <= cfg_data[0];
				smts_pkg::CFG_ZERO:     zero_q     <= cfg_data[smts_pkg::STATE_W-1:0];
				default:                period_q   <= period_q;
			endcase
		end
	end

	// saturate the period to 1..PERIOD_MAX and the zero state to the state range
	always_comb begin
		if (period_q == '0) begin
			cfg.period = smts_pkg::PERIOD_BITS'(1);
		end else if (32'(period_q) > smts_pkg::PERIOD_MAX) begin
			cfg.period = smts_pkg::PERIOD_BITS'(smts_pkg::PERIOD_MAX);
		end else begin
			cfg.period = smts_pkg::PERIOD_BITS'(period_q);
		end
		cfg.seasonal = seasonal_q;
		if (32'(zero_q) >= smts_pkg::STATES) begin
			cfg.zero = smts_pkg::STATE_BITS'(smts_pkg::STATES - 1);
		end else begin
			cfg.zero = smts_pkg::STATE_BITS'(zero_q);
		end
	end

	smts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.result  (result),
		.cfg     (cfg),
		.ctx     (ctx),
		.ctx_cmd (ctx_cmd),
		.pt_req  (pt_req),
		.tt_req  (tt_req),
		.pt_rd   (pt_rd),
		.tt_rd   (tt_rd)
	);

	smts_ctx u_ctx (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (ctx_cmd),
		.ctx    (ctx)
	);

	smts_ram #(
		.DEPTH (smts_pkg::PT_DEPTH),
		.WIDTH (smts_pkg::COUNT_BITS)
	) u_pair_ram (
		.clk   (clk),
		.we    (pt_req.we),
		.waddr (pt_req.waddr),
		.wdata (pt_req.wdata),
		.raddr (pt_req.raddr),
		.rdata (pt_rd)
	);

	smts_ram #(
		.DEPTH (smts_pkg::TT_DEPTH),
		.WIDTH (smts_pkg::COUNT_BITS)
	) u_trans_ram (
		.clk   (clk),
		.we    (tt_req.we),
		.waddr (tt_req.waddr),
		.wdata (tt_req.wdata),
		.raddr (tt_req.raddr),
		.rdata (tt_rd)
	);

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the seasonal Markov chain trainer and sampler. Drives
// observe, generate and restart commands with random gaps on the command
// channel and random stalls on the result channel. A cycle-free model of the
// count tables, the delay line and the season phase predicts every drawn
// state. Each result beat is checked field by field against the oldest
// prediction. Runs directed cases, a sweep of register settings and long
// stretches of train-then-sample sequences.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [smts_pkg::STATE_W-1:0] next_state;
		logic                         unseen;
		logic [smts_pkg::PHASE_W-1:0] phase;
	} draw_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                            cfg_wr_en;
	logic [smts_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [smts_pkg::CFG_DATA_W-1:0] cfg_data;

	smts_item_if   item_ch ();
	smts_result_if result_ch ();

	seasonal_markov_train_and_sample u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// chain model
	logic [smts_pkg::COUNT_BITS-1:0] trans_cnt [smts_pkg::TT_DEPTH];
	logic [smts_pkg::COUNT_BITS-1:0] pair_cnt [smts_pkg::PT_DEPTH];
	logic [smts_pkg::STATE_BITS-1:0] lag_line [smts_pkg::PERIOD_MAX];
	logic [smts_pkg::STATE_BITS-1:0] cur_st;
	bit                              cur_ok;
	int unsigned                     season_ph;
	logic [5:0]                      cfg_period_raw;
	bit                              cfg_seasonal;
	logic [2:0]                      cfg_zero;

	draw_t pending_draws[$];
	int    mismatches = 0;
	int    beats_sent = 0;
	bit    gaps_on = 1'b1;

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic int unsigned lag_len();
		if (cfg_period_raw == 0) return 1;
		if (cfg_period_raw > smts_pkg::PERIOD_MAX) return smts_pkg::PERIOD_MAX;
		return 32'(cfg_period_raw);
	endfunction

	function automatic void clear_tables();
		for (int i = 0; i < smts_pkg::TT_DEPTH; i++) trans_cnt[i] = '0;
		for (int i = 0; i < smts_pkg::PT_DEPTH; i++) pair_cnt[i] = '0;
	endfunction

	function automatic void advance_chain(logic [smts_pkg::STATE_BITS-1:0] dest);
		int unsigned p;
		p = lag_len();
		for (int i = 0; i + 1 < p; i++) lag_line[i] = lag_line[i + 1];
		lag_line[p - 1] = dest;
		cur_st = dest;
		if (cfg_seasonal) season_ph = (season_ph + 1 >= p) ? 0 : season_ph + 1;
	endfunction

	// apply one accepted command; queue the draw it produces, if any
	function automatic void chain_step(smts_pkg::op_t op, logic [2:0] obs, logic [15:0] rf);
		int unsigned ph, pidx, tbase;
		longint unsigned c, cum;
		logic [smts_pkg::STATE_BITS-1:0] dest;
		bit unseen, found;
		draw_t d;
		ph = cfg_seasonal ? season_ph : 0;
		pidx = (ph * smts_pkg::STATES + cur_st) * smts_pkg::STATES + lag_line[0];
		tbase = pidx * smts_pkg::STATES;
		case (op)
			smts_pkg::OP_OBSERVE: begin
				if (!cur_ok) begin
					// first sample after a restart only seeds the chain
					cur_st = obs;
					lag_line[lag_len() - 1] = obs;
					cur_ok = 1'b1;
				end else if (pair_cnt[pidx] < smts_pkg::PAIR_FULL) begin
					pair_cnt[pidx]++;
					trans_cnt[tbase + obs]++;
					advance_chain(obs);
				end
			end
			smts_pkg::OP_GENERATE: begin
				c = pair_cnt[pidx];
				cum = 0;
				dest = cfg_zero;
				unseen = (c == 0);
				found = 1'b0;
				if (!unseen) begin
					for (int j = 0; j < smts_pkg::STATES; j++) begin
						cum += trans_cnt[tbase + j];
						if (!found && rf * c < cum * 65536) begin
							dest = smts_pkg::STATE_BITS'(j);
							found = 1'b1;
						end
					end
				end
				d.next_state = dest;
				d.unseen = unseen;
				d.phase = ph[smts_pkg::PHASE_W-1:0];
				pending_draws.push_back(d);
				cur_ok = 1'b1;
				advance_chain(dest);
			end
			default: begin
				if (op == smts_pkg::OP_RESTART_TRAIN) begin
					clear_tables();
					cur_ok = 1'b0;
				end else begin
					cur_ok = 1'b1;
				end
				for (int i = 0; i < smts_pkg::PERIOD_MAX; i++) lag_line[i] = cfg_zero;
				cur_st = cfg_zero;
				season_ph = 0;
			end
		endcase
	endfunction

	function automatic void reset_model();
		clear_tables();
		for (int i = 0; i < smts_pkg::PERIOD_MAX; i++) lag_line[i] = '0;
		cur_st = '0;
		cur_ok = 1'b0;
		season_ph = 0;
		cfg_period_raw = 6'd1;
		cfg_seasonal = 1'b0;
		cfg_zero = 3'd0;
	endfunction

	// valid stays high from one beat to the next unless a gap is taken
	task automatic send_item(smts_pkg::op_t op, logic [2:0] obs, logic [15:0] rf);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= op;
		item_ch.observed_state <= obs;
		item_ch.random_fraction <= rf;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		chain_step(op, obs, rf);
		beats_sent++;
	endtask

	function automatic logic [15:0] draw_fraction();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_noise();
		case ($urandom_range(0, 2))
			0: send_item(smts_pkg::OP_OBSERVE, 3'($urandom), 16'($urandom));
			1: send_item(smts_pkg::OP_GENERATE, 3'($urandom), draw_fraction());
			default: send_item(smts_pkg::OP_RESTART_GEN, 3'($urandom), 16'($urandom));
		endcase
	endtask

	// drop valid, drain all draws, then give the last observe time to write back
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(smts_pkg::cfg_idx_t idx, logic [5:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			smts_pkg::CFG_PERIOD:   cfg_period_raw = val;
			smts_pkg::CFG_SEASONAL: cfg_seasonal = val[0];
			default:                cfg_zero = val[2:0];
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [5:0] period, bit seasonal, logic [2:0] zero);
		logic [5:0] v;
		settle();
		write_reg(smts_pkg::CFG_PERIOD, period);
		// junk in the unused upper data bits
		v = 6'($urandom);
		v[0] = seasonal;
		write_reg(smts_pkg::CFG_SEASONAL, v);
		v = 6'($urandom);
		v[2:0] = zero;
		write_reg(smts_pkg::CFG_ZERO, v);
	endtask

	// train on a narrow alphabet so later draws hit seen contexts, then sample
	task automatic run_episode(bit retrain, int n_train, int n_draw);
		logic [2:0] base, obs;
		int span;
		base = ($urandom_range(0, 1) != 0) ? cfg_zero : 3'($urandom_range(0, 7));
		span = ($urandom_range(0, 5) == 0) ? 8 : $urandom_range(1, 4);
		if (retrain) send_item(smts_pkg::OP_RESTART_TRAIN, 3'($urandom), 16'($urandom));
		repeat (n_train) begin
			if ($urandom_range(0, 9) == 0) begin
				send_noise();
			end else begin
				obs = base + 3'($urandom_range(0, span - 1));
				send_item(smts_pkg::OP_OBSERVE, obs, 16'($urandom));
			end
		end
		if ($urandom_range(0, 1) != 0)
			send_item(smts_pkg::OP_RESTART_GEN, 3'($urandom), 16'($urandom));
		repeat (n_draw) begin
			if ($urandom_range(0, 9) == 0) send_noise();
			else send_item(smts_pkg::OP_GENERATE, 3'($urandom), draw_fraction());
		end
		send_item(smts_pkg::OP_GENERATE, 3'($urandom), draw_fraction());
	endtask

	task automatic test_directed();
		send_item(smts_pkg::OP_OBSERVE, 3'd7, 16'h0000);    // seeds the chain only
		send_item(smts_pkg::OP_OBSERVE, 3'd0, 16'hFFFF);
		send_item(smts_pkg::OP_OBSERVE, 3'd7, 16'h0000);
		send_item(smts_pkg::OP_OBSERVE, 3'd0, 16'hFFFF);
		send_item(smts_pkg::OP_OBSERVE, 3'd7, 16'h0000);
		send_item(smts_pkg::OP_GENERATE, 3'd0, 16'h0000);
		send_item(smts_pkg::OP_GENERATE, 3'd7, 16'hFFFF);
		send_item(smts_pkg::OP_OBSERVE, 3'd3, 16'h5555);
		send_item(smts_pkg::OP_RESTART_GEN, 3'd0, 16'h0000);
		send_item(smts_pkg::OP_GENERATE, 3'd0, 16'hFFFF);
		// lands on the last bucket of a three-count context
		send_item(smts_pkg::OP_GENERATE, 3'd0, 16'hFFFF);
		send_item(smts_pkg::OP_GENERATE, 3'd7, 16'h5555);  // unseen context
		send_item(smts_pkg::OP_GENERATE, 3'd0, 16'h0001);
		send_item(smts_pkg::OP_RESTART_TRAIN, 3'd7, 16'hFFFF);
		send_item(smts_pkg::OP_GENERATE, 3'd0, 16'h8000);  // sample before any training
		send_item(smts_pkg::OP_OBSERVE, 3'd5, 16'h0000);   // counted: sampling set the chain
		send_item(smts_pkg::OP_GENERATE, 3'd2, 16'hFFFE);
		send_item(smts_pkg::OP_OBSERVE, 3'd1, 16'h0000);
		send_item(smts_pkg::OP_GENERATE, 3'd4, 16'hAAAA);
	endtask

	task automatic test_config_sweep();
		logic [5:0] periods [8] = '{6'd0, 6'd63, 6'd5, 6'd32, 6'd33, 6'd1, 6'd17, 6'd2};
		bit         seasons [8] = '{1, 1, 1, 0, 1, 1, 1, 0};
		logic [2:0] zeros   [8] = '{3'd7, 3'd0, 3'd3, 3'd7, 3'd5, 3'd1, 3'd6, 3'd2};
		bit         retrain [8] = '{1, 1, 0, 1, 0, 1, 0, 1};
		for (int i = 0; i < 8; i++) begin
			// settings without a restart keep a phase that may exceed the new period
			set_config(periods[i], seasons[i], zeros[i]);
			run_episode(retrain[i], $urandom_range(12, 30), $urandom_range(6, 14));
		end
	endtask

	task automatic test_random_traffic();
		int start, ep;
		start = beats_sent;
		ep = 0;
		while (beats_sent - start < 40) begin
			if (ep % 3 == 2)
				set_config(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
					3'($urandom_range(0, 7)));
			gaps_on = ($urandom_range(0, 3) != 0);
			run_episode($urandom_range(0, 3) == 0, $urandom_range(6, 30), $urandom_range(4, 20));
			ep++;
		end
	endtask

	task automatic test_steady_stream();
		gaps_on = 1'b0;
		set_config(6'($urandom_range(1, 32)), 1'b1, 3'($urandom_range(0, 7)));
		run_episode(1'b0, 30, 20);
		run_episode(1'b0, 20, 20);
	endtask

	// result-side stalls
	initial begin
		int stall;
		stall = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				result_ch.ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 19) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		draw_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_draws.size() == 0) begin
				flag_mismatch("unexpected result beat, next_state",
					int'(result_ch.next_state), -1);
			end else begin
				want = pending_draws.pop_front();
				if (result_ch.next_state !== want.next_state)
					flag_mismatch("next_state", int'(result_ch.next_state),
						int'(want.next_state));
				if (result_ch.unseen_context !== want.unseen)
					flag_mismatch("unseen_context", int'(result_ch.unseen_context),
						int'(want.unseen));
				if (result_ch.phase_used !== want.phase)
					flag_mismatch("phase_used", int'(result_ch.phase_used),
						int'(want.phase));
			end
		end
	end

	initial begin
		#(10_000_000);
		$display("FAIL seasonal_markov_train_and_sample");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = smts_pkg::CFG_PERIOD;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.opcode = smts_pkg::OP_OBSERVE;
		item_ch.observed_state = '0;
		item_ch.random_fraction = '0;
		reset_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random_traffic();
		test_steady_stream();
		settle();
		if (mismatches == 0)
			$display("PASS seasonal_markov_train_and_sample");
		else
			$display("FAIL seasonal_markov_train_and_sample");
		$finish;
	end

endmodule

/* sim.f */
design/smts_pkg.sv
design/smts_item_if.sv
design/smts_result_if.sv
design/smts_ram.sv
design/smts_ctx.sv
design/smts_ctrl.sv
design/seasonal_markov_train_and_sample.sv
dv/tb.sv
